// ----- hdl/b32sc_pkg.sv -----
package b32sc_pkg;

    localparam int unsigned QueueDepth  = 2;
    localparam int unsigned ResultSlots = 3;

    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    // register index is carried by paddr[2]
    localparam logic RegDirection = 1'b0;

    localparam logic [3:0] GroupBits = 4'd5;
    localparam logic [3:0] ByteBits  = 4'd8;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       data_present;
        logic       last;
        logic       bad_char;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [ResultSlots-1:0]    slot;
    } bundle_t;

    // 5-bit group to alphabet character
    function automatic logic [7:0] sym_of(input logic [4:0] v);
        logic [7:0] wide;
        wide = {3'b000, v};
        if (v < 5'd26) begin
            return 8'h41 + wide;
        end
        return 8'h31 + wide - 8'd26;
    endfunction

    // character to {valid, group}
    function automatic logic [5:0] val_of(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            diff = c - 8'h41;
            return {1'b1, diff[4:0]};
        end
        if (c >= 8'h31 && c <= 8'h36) begin
            diff = c - 8'h31 + 8'd26;
            return {1'b1, diff[4:0]};
        end
        return 6'b000000;
    endfunction

endpackage

// ----- hdl/b32sc_front.sv -----
module b32sc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                direction,
    input  logic                cfg_clear,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_end_of_message,
    input  logic                q_ready,
    output logic                q_push,
    output b32sc_pkg::bundle_t  q_bundle
);

    logic [11:0] buf_reg, buf_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        err_reg, err_next;

    logic [11:0] buf_a;
    logic [3:0]  cnt_a;
    logic [3:0]  pad_sh;
    logic [11:0] shifted;
    logic [5:0]  vv;
    logic [1:0]  n;
    b32sc_pkg::result_t [b32sc_pkg::ResultSlots-1:0] res;
    logic        accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        res      = '0;
        n        = 2'd0;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        buf_a    = 12'h000;
        cnt_a    = 4'd0;
        pad_sh   = 4'd0;
        shifted  = 12'h000;
        vv       = b32sc_pkg::val_of(s_in_byte);
        if (direction == b32sc_pkg::DirEncode) begin
            buf_a   = {buf_reg[3:0], s_in_byte};
            cnt_a   = cnt_reg + b32sc_pkg::ByteBits - b32sc_pkg::GroupBits;
            shifted = buf_a >> cnt_a;
            res[0]  = '{b32sc_pkg::sym_of(shifted[4:0]), 1'b1, 1'b0, 1'b0};
            n       = 2'd1;
            if (cnt_a >= b32sc_pkg::GroupBits) begin
                cnt_a   = cnt_a - b32sc_pkg::GroupBits;
                shifted = buf_a >> cnt_a;
                res[1]  = '{b32sc_pkg::sym_of(shifted[4:0]), 1'b1, 1'b0, 1'b0};
                n       = 2'd2;
            end
            if (s_end_of_message) begin
                if (cnt_a != 4'd0) begin
                    // pad leftover bits with zeros on the right
                    pad_sh  = b32sc_pkg::GroupBits - cnt_a;
                    shifted = buf_a << pad_sh;
                    res[n]  = '{b32sc_pkg::sym_of(shifted[4:0]), 1'b1, 1'b0, 1'b0};
                    n       = n + 2'd1;
                end
                res[n - 2'd1].last = 1'b1;
                buf_next = 12'h000;
                cnt_next = 4'd0;
                err_next = 1'b0;
            end else begin
                buf_next = buf_a;
                cnt_next = cnt_a;
            end
        end else if (err_reg) begin
            // drop input until the end of the message
            if (s_end_of_message) begin
                res[0]   = '{8'h00, 1'b0, 1'b1, 1'b1};
                n        = 2'd1;
                buf_next = 12'h000;
                cnt_next = 4'd0;
                err_next = 1'b0;
            end
        end else if (!vv[5]) begin
            res[0] = '{8'h00, 1'b0, s_end_of_message, 1'b1};
            n      = 2'd1;
            if (s_end_of_message) begin
                buf_next = 12'h000;
                cnt_next = 4'd0;
                err_next = 1'b0;
            end else begin
                err_next = 1'b1;
            end
        end else begin
            buf_a = {buf_reg[6:0], vv[4:0]};
            cnt_a = cnt_reg + b32sc_pkg::GroupBits;
            if (cnt_a >= b32sc_pkg::ByteBits) begin
                cnt_a   = cnt_a - b32sc_pkg::ByteBits;
                shifted = buf_a >> cnt_a;
                res[0]  = '{shifted[7:0], 1'b1, 1'b0, 1'b0};
                n       = 2'd1;
            end
            if (s_end_of_message) begin
                if (n != 2'd0) begin
                    res[0].last = 1'b1;
                end else begin
                    res[0] = '{8'h00, 1'b0, 1'b1, 1'b0};
                    n      = 2'd1;
                end
                buf_next = 12'h000;
                cnt_next = 4'd0;
                err_next = 1'b0;
            end else begin
                buf_next = buf_a;
                cnt_next = cnt_a;
            end
        end
    end

    assign q_push         = accept && (n != 2'd0);
    assign q_bundle.count = n;
    assign q_bundle.slot  = res;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            buf_reg <= 12'h000;
            cnt_reg <= 4'd0;
            err_reg <= 1'b0;
        end else if (accept) begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

endmodule

// ----- hdl/b32sc_queue.sv -----
module b32sc_queue #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_push,
    input  logic [Width-1:0] in_data,
    output logic             in_ready,
    input  logic             out_pop,
    output logic             out_valid,
    output logic [Width-1:0] out_data
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    logic [Width-1:0] entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             do_push, do_pop;

    assign in_ready  = (cnt_reg != FullCnt);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_push   = in_push && in_ready;
    assign do_pop    = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/b32sc_back.sv -----
module b32sc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  b32sc_pkg::bundle_t  q_bundle,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_data_present,
    output logic                m_last,
    output logic                m_bad_char
);

    b32sc_pkg::bundle_t cur_reg;
    logic               cur_valid_reg;
    logic [1:0]         idx_reg;
    logic               m_valid_reg;
    b32sc_pkg::result_t m_data_reg;

    logic load, fire, last_slot, cur_free;

    assign load      = !m_valid_reg || m_ready;
    assign fire      = cur_valid_reg && load;
    assign last_slot = (idx_reg == cur_reg.count - 2'd1);
    assign cur_free  = !cur_valid_reg || (fire && last_slot);
    assign q_pop     = q_valid && cur_free;

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= cur_reg.slot[idx_reg];
        end
        if (q_pop) begin
            cur_reg <= q_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= cur_valid_reg;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (fire) begin
                // advance to the next slot or retire the bundle
                if (last_slot) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_data_reg.out_byte;
    assign m_data_present = m_data_reg.data_present;
    assign m_last         = m_data_reg.last;
    assign m_bad_char     = m_data_reg.bad_char;

endmodule

// ----- hdl/base32_stream_codec_unit.sv -----
// Unpadded Base32 codec (alphabet A-Z then 1-6) for byte streams; the direction register
// at address 0 picks encode (0) or decode (1), and writing it clears the message state.
// The front end takes one request per cycle while the queue has room, and turns it into
// a bundle of up to three results, which waits in a two-entry queue; the back end sends
// one result per cycle while m_ready is high, from its output register. An encoded byte
// yields one to three characters, one result each; a decoded character yields at most
// one. The sustained rate is set by the single result per cycle of the back end.
module base32_stream_codec_unit #(
    parameter int unsigned QueueDepth = b32sc_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_data_present,
    output logic        m_last,
    output logic        m_bad_char,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               direction_reg;
    logic               cfg_clear;
    logic               q_push, q_ready, q_valid, q_pop;
    b32sc_pkg::bundle_t push_bundle, head_bundle;

    assign pready    = 1'b1;
    assign cfg_clear = psel && penable && pwrite && (paddr[2] == b32sc_pkg::RegDirection);
    assign prdata    = (paddr[2] == b32sc_pkg::RegDirection) ? {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= b32sc_pkg::DirEncode;
        end else if (cfg_clear) begin
            direction_reg <= pwdata[0];
        end
    end

    b32sc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .direction        (direction_reg),
        .cfg_clear        (cfg_clear),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .q_ready          (q_ready),
        .q_push           (q_push),
        .q_bundle         (push_bundle)
    );

    b32sc_queue #(
        .Width ($bits(b32sc_pkg::bundle_t)),
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (q_push),
        .in_data   (push_bundle),
        .in_ready  (q_ready),
        .out_pop   (q_pop),
        .out_valid (q_valid),
        .out_data  (head_bundle)
    );

    b32sc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_bundle       (head_bundle),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_data_present (m_data_present),
        .m_last         (m_last),
        .m_bad_char     (m_bad_char)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] DirAddr      = {b32sc_pkg::RegDirection, 2'b00};
    localparam logic [2:0] SpareAddr    = 3'h4;
    localparam int         SettleCycles = 8;
    localparam int         HoldOffCycles = 60;
    localparam int         RandomItems  = 400;
    localparam b32sc_pkg::result_t NoResult = '0;

    typedef struct packed {
        logic                          dir;
        logic                          rewrite;
        logic [7:0]                    data;
        logic                          eom;
        logic [1:0]                    n_pin;
        b32sc_pkg::result_t [1:0]      pin;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_data_present;
    logic        m_last;
    logic        m_bad_char;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic        cfg_dir;
    logic [11:0] bit_acc;
    logic [3:0]  bit_fill;
    logic        err_latched;

    b32sc_pkg::result_t pending[$];
    stim_row_t   dir_rows[$];
    int          fail_count = 0;
    int          counted_items = 0;
    int          src_idle_pct = 22;
    int          snk_idle_pct = 71;
    logic        hold_off_req = 1'b0;

    base32_stream_codec_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_data_present   (m_data_present),
        .m_last           (m_last),
        .m_bad_char       (m_bad_char),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic b32sc_pkg::result_t mk_result(input logic [7:0] b, input logic p,
                                                     input logic l, input logic bad);
        return b32sc_pkg::result_t'({b, p, l, bad});
    endfunction

    function automatic logic [7:0] group_char(input logic [4:0] g);
        if (g < 5'd26) begin
            return "A" + {3'b000, g};
        end
        return "1" + ({3'b000, g} - 8'd26);
    endfunction

    // {known, group}
    function automatic logic [5:0] char_group(input logic [7:0] c);
        logic [7:0] off;
        off = 8'h00;
        if (c >= "A" && c <= "Z") begin
            off = c - "A";
            return {1'b1, off[4:0]};
        end
        if (c >= "1" && c <= "6") begin
            off = c - "1" + 8'd26;
            return {1'b1, off[4:0]};
        end
        return 6'b000000;
    endfunction

    function automatic void clear_message();
        bit_acc     = '0;
        bit_fill    = '0;
        err_latched = 1'b0;
    endfunction

    // Append one expected result to the tail of the queue.
    function automatic void append_result(input b32sc_pkg::result_t r);
        pending = {pending, r};
    endfunction

    // Advance the codec state by one request; return the results it gives.
    function automatic int base32_predict(input logic [7:0] d, input logic e,
                                          output b32sc_pkg::result_t [2:0] r);
        int n;
        logic [5:0] cg;
        n = 0;
        r = '0;
        if (cfg_dir == b32sc_pkg::DirEncode) begin
            bit_acc  = {bit_acc[3:0], d};
            bit_fill = bit_fill + 4'd8;
            while (bit_fill >= b32sc_pkg::GroupBits && n < 3) begin
                bit_fill = bit_fill - b32sc_pkg::GroupBits;
                r[n] = mk_result(group_char(5'(bit_acc >> bit_fill)), 1'b1, 1'b0, 1'b0);
                n++;
            end
            if (e) begin
                if (bit_fill > 0 && bit_fill < b32sc_pkg::GroupBits && n < 3) begin
                    r[n] = mk_result(
                        group_char(5'(bit_acc << (b32sc_pkg::GroupBits - bit_fill))),
                        1'b1, 1'b0, 1'b0);
                    n++;
                end
                if (n > 0) begin
                    r[n-1].last = 1'b1;
                end else begin
                    r[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                    n = 1;
                end
                clear_message();
            end
            return n;
        end
        if (err_latched) begin
            if (!e) begin
                return 0;
            end
            r[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b1);
            clear_message();
            return 1;
        end
        cg = char_group(d);
        if (!cg[5]) begin
            r[0] = mk_result(8'h00, 1'b0, e, 1'b1);
            if (e) begin
                clear_message();
            end else begin
                err_latched = 1'b1;
            end
            return 1;
        end
        bit_acc  = {bit_acc[6:0], cg[4:0]};
        bit_fill = bit_fill + b32sc_pkg::GroupBits;
        while (bit_fill >= b32sc_pkg::ByteBits && n < 3) begin
            bit_fill = bit_fill - b32sc_pkg::ByteBits;
            r[n] = mk_result(8'(bit_acc >> bit_fill), 1'b1, 1'b0, 1'b0);
            n++;
        end
        if (e) begin
            if (n > 0) begin
                r[n-1].last = 1'b1;
            end else begin
                r[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b0);
                n = 1;
            end
            clear_message();
        end
        return n;
    endfunction

    task automatic add_row(input logic dr, input logic rw, input logic [7:0] d, input logic e,
                           input logic [1:0] np, input b32sc_pkg::result_t p0,
                           input b32sc_pkg::result_t p1);
        stim_row_t row;
        row.dir     = dr;
        row.rewrite = rw;
        row.data    = d;
        row.eom     = e;
        row.n_pin   = np;
        row.pin[0]  = p0;
        row.pin[1]  = p1;
        dir_rows    = {dir_rows, row};
    endtask

    // Called just after a falling edge; returns just after the falling edge past acceptance.
    task automatic send_request(input logic [7:0] d, input logic e, input logic [1:0] np,
                                input b32sc_pkg::result_t [1:0] pins);
        b32sc_pkg::result_t [2:0] outs;
        int n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_in_byte        <= d;
        s_end_of_message <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!(cfg_dir == b32sc_pkg::DirDecode && err_latched)) counted_items++;
        n = base32_predict(d, e, outs);
        if (np != 0) begin
            for (int i = 0; i < np; i++) append_result(pins[i]);
        end else begin
            for (int i = 0; i < n; i++) append_result(outs[i]);
        end
        @(negedge aclk);
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    // Write one register, then read the direction back.
    task automatic reg_write(input logic [2:0] addr, input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'b0, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == DirAddr) begin
            cfg_dir = v;
            clear_message();
        end
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DirAddr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {31'b0, cfg_dir}) begin
            $display("%0t: direction read expected %0h got %0h", $time, {31'b0, cfg_dir},
                     prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        b32sc_pkg::result_t got;
        b32sc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = mk_result(m_out_byte, m_data_present, m_last, m_bad_char);
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, expected none got %h", $time, got);
                fail_count++;
            end else begin
                want = pending.pop_front();
                check_field("out_byte", int'(want.out_byte), int'(got.out_byte));
                check_field("data_present", int'(want.data_present), int'(got.data_present));
                check_field("last", int'(want.last), int'(got.last));
                check_field("bad_char", int'(want.bad_char), int'(got.bad_char));
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        int   hold_left;
        logic hold_taken;
        if (!aresetn) begin
            hold_left  = 0;
            hold_taken = 1'b0;
            m_ready   <= 1'b0;
        end else begin
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HoldOffCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        stim_row_t  row;
        int         msg_len;
        logic [7:0] c;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_in_byte        = 8'h00;
        s_end_of_message = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cfg_dir          = b32sc_pkg::DirEncode;
        clear_message();

        // encode: extremes, a message ending on three characters, clear mid-message
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'h00, 1'b1, 2'd2,
                mk_result("A", 1'b1, 1'b0, 1'b0), mk_result("A", 1'b1, 1'b1, 1'b0));
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'hFF, 1'b1, 2'd2,
                mk_result("6", 1'b1, 1'b0, 1'b0), mk_result("3", 1'b1, 1'b1, 1'b0));
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'hA5, 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'h5A, 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'hC3, 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'h3C, 1'b1, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirEncode, 1'b0, 8'h81, 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirEncode, 1'b1, 8'hFF, 1'b1, 2'd2,
                mk_result("6", 1'b1, 1'b0, 1'b0), mk_result("3", 1'b1, 1'b1, 1'b0));
        // decode: extremes, bare end marker, unknown characters, clear mid-message
        add_row(b32sc_pkg::DirDecode, 1'b0, "6", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "6", 1'b1, 2'd1,
                mk_result(8'hFF, 1'b1, 1'b1, 1'b0), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "A", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "A", 1'b1, 2'd1,
                mk_result(8'h00, 1'b1, 1'b1, 1'b0), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "A", 1'b1, 2'd1,
                mk_result(8'h00, 1'b0, 1'b1, 1'b0), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "@", 1'b0, 2'd1,
                mk_result(8'h00, 1'b0, 1'b0, 1'b1), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "B", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, 8'hFF, 1'b1, 2'd1,
                mk_result(8'h00, 1'b0, 1'b1, 1'b1), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "7", 1'b1, 2'd1,
                mk_result(8'h00, 1'b0, 1'b1, 1'b1), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, 8'h00, 1'b1, 2'd1,
                mk_result(8'h00, 1'b0, 1'b1, 1'b1), NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "Z", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "1", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "Q", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "5", 1'b1, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b0, "Q", 1'b0, 2'd0, NoResult, NoResult);
        add_row(b32sc_pkg::DirDecode, 1'b1, "A", 1'b1, 2'd1,
                mk_result(8'h00, 1'b0, 1'b1, 1'b0), NoResult);

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        reg_write(DirAddr, b32sc_pkg::DirEncode);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.dir != cfg_dir || row.rewrite) begin
                settle();
                reg_write(DirAddr, row.dir);
            end
            send_request(row.data, row.eom, row.n_pin, row.pin);
        end

        // the spare address must leave the direction alone
        settle();
        reg_write(SpareAddr, ~cfg_dir);

        counted_items = 0;
        while (counted_items < RandomItems) begin
            if ($urandom_range(3) == 0) begin
                settle();
                reg_write(DirAddr, 1'($urandom_range(1)));
            end
            msg_len = ($urandom_range(7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            for (int k = 0; k < msg_len; k++) begin
                if (counted_items < RandomItems / 3) begin
                    src_idle_pct = 22;
                    snk_idle_pct = 71;
                end else if (counted_items < 2 * RandomItems / 3) begin
                    src_idle_pct = 71;
                    snk_idle_pct = 22;
                end else begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                // starve the output once while requests keep coming
                if (counted_items >= 3 * RandomItems / 4) hold_off_req = 1'b1;
                if (k != 0 && $urandom_range(39) == 0) begin
                    settle();
                    reg_write(DirAddr, 1'($urandom_range(1)));
                end
                if (cfg_dir == b32sc_pkg::DirEncode || $urandom_range(15) == 0) begin
                    c = 8'($urandom_range(255));
                end else begin
                    c = group_char(5'($urandom_range(31)));
                end
                send_request(c, k == msg_len - 1, 2'd0, {NoResult, NoResult});
            end
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/b32sc_pkg.sv
hdl/b32sc_front.sv
hdl/b32sc_queue.sv
hdl/b32sc_back.sv
hdl/base32_stream_codec_unit.sv
verif/tb.sv
